// ===== design/rtpdf_pkg.sv =====
// Package for the interleaved RTP deframer.
// Holds the frame and header constants and the result struct; depends on nothing.
package rtpdf_pkg;

   localparam int unsigned POS_W = 17;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned SEQ_W = 16;
   localparam int unsigned TS_W  = 32;

   localparam logic [7:0] MAGIC_BYTE  = 8'h24;
   localparam logic [7:0] RTP_V2      = 8'h80;
   localparam logic [7:0] RTP_PT_BYTE = 8'h60;
   localparam logic [7:0] MARKER_BIT  = 8'h80;

   localparam logic [POS_W-1:0] PREFIX_BYTES = POS_W'(4);

   localparam logic [TS_W-1:0] SAMPLES_RESET = TS_W'(4096);

   // One result of the deframer, before the output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rtpdf_result_type;

endpackage

// ===== design/rtpdf_core.sv =====
// Frame parser and RTP header rewriter of the interleaved RTP deframer.
// Holds all stream state and turns one byte into zero or one result; uses rtpdf_pkg.
module rtpdf_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [7:0]                      in_byte,
   input  logic [rtpdf_pkg::TS_W-1:0]      samples_per_packet,
   output rtpdf_pkg::rtpdf_result_type     result
);
   import rtpdf_pkg::*;

   // Payload offsets of the rewritten header bytes.
   localparam logic [POS_W-1:0] HDR_VERSION = POS_W'(0);
   localparam logic [POS_W-1:0] HDR_TYPE    = POS_W'(1);
   localparam logic [POS_W-1:0] HDR_SEQ_HI  = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_SEQ_LO  = POS_W'(3);
   localparam logic [POS_W-1:0] HDR_TS_3    = POS_W'(4);
   localparam logic [POS_W-1:0] HDR_TS_2    = POS_W'(5);
   localparam logic [POS_W-1:0] HDR_TS_1    = POS_W'(6);
   localparam logic [POS_W-1:0] HDR_TS_0    = POS_W'(7);

   logic [POS_W-1:0] position_ff, position_in;
   logic [LEN_W-1:0] pkt_len_ff, pkt_len_in;
   logic             rewriting_ff, rewriting_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [TS_W-1:0]  ts_ff, ts_in;
   logic [SEQ_W-1:0] lat_seq_ff, lat_seq_in;
   logic [TS_W-1:0]  lat_ts_ff, lat_ts_in;
   logic             first_done_ff, first_done_in;
   logic             halted_ff, halted_in;

   logic [POS_W-1:0] offset;
   logic             is_last;
   logic             rewrite_now;
   logic [7:0]       rewritten;
   logic [LEN_W-1:0] new_len;

   assign offset  = position_ff - PREFIX_BYTES;
   assign is_last = (offset + POS_W'(1)) >= {1'b0, pkt_len_ff};
   assign new_len = {pkt_len_ff[LEN_W-1:8], in_byte};

   // The first payload byte decides whether this packet gets a new header.
   assign rewrite_now = (offset == HDR_VERSION) ? (in_byte != RTP_V2) : rewriting_ff;

   always_comb begin
      case (offset)
         HDR_VERSION: rewritten = RTP_V2;
         HDR_TYPE:    rewritten = RTP_PT_BYTE | (first_done_ff ? 8'h00 : MARKER_BIT);
         HDR_SEQ_HI:  rewritten = lat_seq_ff[15:8];
         HDR_SEQ_LO:  rewritten = lat_seq_ff[7:0];
         HDR_TS_3:    rewritten = lat_ts_ff[31:24];
         HDR_TS_2:    rewritten = lat_ts_ff[23:16];
         HDR_TS_1:    rewritten = lat_ts_ff[15:8];
         HDR_TS_0:    rewritten = lat_ts_ff[7:0];
         default:     rewritten = in_byte;
      endcase
   end

   always_comb begin
      position_in   = position_ff;
      pkt_len_in    = pkt_len_ff;
      rewriting_in  = rewriting_ff;
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      lat_seq_in    = lat_seq_ff;
      lat_ts_in     = lat_ts_ff;
      first_done_in = first_done_ff;
      halted_in     = halted_ff;
      result        = '0;

      if (halted_ff) begin
         result = '0;
      end else if (position_ff < PREFIX_BYTES) begin
         case (position_ff[1:0])
            2'd0: begin
               if (in_byte != MAGIC_BYTE) begin
                  halted_in       = 1'b1;
                  result.valid    = 1'b1;
                  result.out_byte = in_byte;
                  result.error    = 1'b1;
               end else begin
                  position_in = POS_W'(1);
               end
            end
            2'd1: begin
               position_in = POS_W'(2);
            end
            2'd2: begin
               pkt_len_in  = {in_byte, 8'h00};
               position_in = POS_W'(3);
            end
            default: begin
               pkt_len_in   = new_len;
               position_in  = (new_len == '0) ? '0 : PREFIX_BYTES;
               rewriting_in = 1'b0;
            end
         endcase
      end else begin
         result.valid    = 1'b1;
         result.last     = is_last;
         result.out_byte = rewrite_now ? rewritten : in_byte;
         rewriting_in    = rewrite_now;
         if (offset == HDR_VERSION && rewrite_now) begin
            lat_seq_in = seq_ff;
            lat_ts_in  = ts_ff;
            seq_in     = seq_ff + SEQ_W'(1);
            ts_in      = ts_ff + samples_per_packet;
         end
         if (rewrite_now && (offset == HDR_TYPE || (offset == HDR_VERSION && is_last))) begin
            first_done_in = 1'b1;
         end
         if (is_last) begin
            position_in  = '0;
            rewriting_in = 1'b0;
         end else begin
            position_in = position_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         pkt_len_ff    <= '0;
         rewriting_ff  <= 1'b0;
         seq_ff        <= '0;
         ts_ff         <= '0;
         lat_seq_ff    <= '0;
         lat_ts_ff     <= '0;
         first_done_ff <= 1'b0;
         halted_ff     <= 1'b0;
      end else if (fire) begin
         position_ff   <= position_in;
         pkt_len_ff    <= pkt_len_in;
         rewriting_ff  <= rewriting_in;
         seq_ff        <= seq_in;
         ts_ff         <= ts_in;
         lat_seq_ff    <= lat_seq_in;
         lat_ts_ff     <= lat_ts_in;
         first_done_ff <= first_done_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

// ===== design/interleaved_rtp_deframer.sv =====
// Interleaved RTP deframer: an accepted req byte waits in the input register until the
// result register is free or emptied; rsp_valid rises once its result is loaded there.
// Throughput is one byte per cycle while rsp_ready is high; the parse
// and rewrite in rtpdf_core are combinational between the input and result registers.
// Prefix bytes and zero-length frames produce no result; a bad magic byte gives one error
// result. Synchronous active-high reset clears the stream state, the sequence number and
// timestamp, and sets the sample increment to 4096. Uses rtpdf_pkg and rtpdf_core.
module interleaved_rtp_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last,
   output logic                       rsp_error,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rtpdf_pkg::TS_W-1:0] csr_samples_per_packet
);
   import rtpdf_pkg::*;

   // The sample increment register. Writes are always taken; the user must send them only
   // while idle, so no transaction in flight sees a change; the block does not enforce this.
   logic [TS_W-1:0] samples_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= SAMPLES_RESET;
      end else if (csr_valid) begin
         samples_ff <= csr_samples_per_packet;
      end
   end

   // Input register. A byte leaves it when the result register is free or is being emptied
   // in the same cycle, so while results are taken a new transaction can enter every cycle.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // The parser and header rewriter. Its state moves only when the byte in
   // the input register is consumed.
   rtpdf_result_type result;

   rtpdf_core u_core (
      .clock              (clock),
      .reset              (reset),
      .fire               (advance),
      .in_byte            (in_byte_ff),
      .samples_per_packet (samples_ff),
      .result             (result)
   );

   // Result register. It loads the core's result when a byte is consumed; a
   // byte that yields nothing leaves it empty.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_error_ff;

   assign out_valid_in = advance ? result.valid : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff  <= result.out_byte;
         out_last_ff  <= result.last;
         out_error_ff <= result.error;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_error    = out_error_ff;

`ifndef ASSERT_OFF
   // An error result never marks the end of a packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_last)
      else $error("error result carries last");

   // Once the error transaction has gone out, the block stays silent until reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_error |=> !rsp_valid)
      else $error("result after error");

   // A result appears only when a byte has just left the input register.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(advance))
      else $error("result without a consumed byte");
`endif

endmodule

// ===== tb/interleaved_rtp_deframer_tb.sv =====
// Self-checking testbench for the interleaved RTP deframer: framed byte stream in, RTP bytes out.
// Holds a scoreboard class with its own model of the deframer, plus the stimulus and sink.
// Depends on rtpdf_pkg and the interleaved_rtp_deframer RTL.
module interleaved_rtp_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtpdf_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 10;
   // A prefix byte can still sit in the input register when no results are pending; wait
   // this margin before a CSR write so such a byte has settled.
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_CYCLES    = 400;
   localparam int GAP_PERCENT    = 15;
   localparam int STALL_PERCENT  = 20;
   localparam longint TIMEOUT_NS = 20_000_000;

   // How the first payload byte of a generated frame is chosen.
   typedef enum int {
      HDR_ANY,
      HDR_KEEP,
      HDR_REWRITE
   } hdr_mode_type;

   // Scoreboard: tracks the deframer state, predicts the result of each accepted input
   // transaction and compares the results the block delivers, oldest first.
   class rtp_stream_scoreboard;
      logic [TS_W-1:0]  samples;
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] pkt_len;
      bit               rewriting;
      logic [SEQ_W-1:0] seq_next;
      logic [TS_W-1:0]  ts_next;
      logic [SEQ_W-1:0] seq_cur;
      logic [TS_W-1:0]  ts_cur;
      bit               marker_sent;
      bit               halted;
      rtpdf_result_type expected_q[$];
      int               mismatches;

      function new();
         samples     = SAMPLES_RESET;
         pos         = '0;
         pkt_len     = '0;
         rewriting   = 1'b0;
         seq_next    = '0;
         ts_next     = '0;
         seq_cur     = '0;
         ts_cur      = '0;
         marker_sent = 1'b0;
         halted      = 1'b0;
         mismatches  = 0;
      endfunction

      function void set_samples(logic [TS_W-1:0] value);
         samples = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_input(logic [7:0] b);
         rtpdf_result_type r;
         int               k;
         bit               is_last;
         if (halted)
            return;
         r.valid = 1'b1;
         if (pos < PREFIX_BYTES) begin
            case (pos)
               0: begin
                  if (b != MAGIC_BYTE) begin
                     // A bad magic byte is reported once, then the stream is dead.
                     halted     = 1'b1;
                     r.out_byte = b;
                     r.last     = 1'b0;
                     r.error    = 1'b1;
                     expected_q.push_back(r);
                  end else begin
                     pos = POS_W'(1);
                  end
               end
               1: pos = POS_W'(2);
               2: begin
                  pkt_len[15:8] = b;
                  pos           = POS_W'(3);
               end
               default: begin
                  pkt_len[7:0] = b;
                  pos          = (pkt_len == '0) ? '0 : PREFIX_BYTES;
                  rewriting    = 1'b0;
               end
            endcase
            return;
         end
         k       = int'(pos - PREFIX_BYTES);
         is_last = (k + 1 >= int'(pkt_len));
         if (k == 0) begin
            // The header is replaced when the packet does not already start as RTP v2.
            rewriting = (b != RTP_V2);
            if (rewriting) begin
               seq_cur  = seq_next;
               ts_cur   = ts_next;
               seq_next = seq_next + SEQ_W'(1);
               ts_next  = ts_next + samples;
            end
         end
         r.out_byte = b;
         if (rewriting) begin
            case (k)
               0: r.out_byte = RTP_V2;
               1: begin
                  r.out_byte  = RTP_PT_BYTE | (marker_sent ? 8'h00 : MARKER_BIT);
                  marker_sent = 1'b1;
               end
               2: r.out_byte = seq_cur[15:8];
               3: r.out_byte = seq_cur[7:0];
               4: r.out_byte = ts_cur[31:24];
               5: r.out_byte = ts_cur[23:16];
               6: r.out_byte = ts_cur[15:8];
               7: r.out_byte = ts_cur[7:0];
               default: ;
            endcase
            // A one-byte rewritten packet still uses up the marker.
            if (k == 0 && is_last)
               marker_sent = 1'b1;
         end
         r.last  = is_last;
         r.error = 1'b0;
         expected_q.push_back(r);
         if (is_last) begin
            pos       = '0;
            rewriting = 1'b0;
         end else begin
            pos = pos + POS_W'(1);
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task check_result(logic [7:0] out_byte, logic last, logic error);
         rtpdf_result_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h last=%b error=%b",
                                      out_byte, last, error));
            return;
         end
         e = expected_q.pop_front();
         if (out_byte !== e.out_byte)
            report_mismatch($sformatf("out_byte got %02h expected %02h", out_byte, e.out_byte));
         if (last !== e.last)
            report_mismatch($sformatf("last got %b expected %b", last, e.last));
         if (error !== e.error)
            report_mismatch($sformatf("error got %b expected %b", error, e.error));
      endtask
   endclass

   // All block inputs start at known values; reset is held from time zero.
   logic             clock                  = 1'b0;
   logic             reset                  = 1'b1;
   logic             req_valid              = 1'b0;
   logic             req_ready;
   logic [7:0]       req_in_byte            = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready              = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last;
   logic             rsp_error;
   logic             csr_valid              = 1'b0;
   logic             csr_ready;
   logic [TS_W-1:0]  csr_samples_per_packet = '0;

   rtp_stream_scoreboard sb;

   // Shared between the stimulus and the sink: whether random idling is allowed right now,
   // and a request for one long receiver hold-off.
   bit idle_on      = 1'b1;
   int hold_request = 0;
   int items_sent   = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   interleaved_rtp_deframer dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_in_byte            (req_in_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last               (rsp_last),
      .rsp_error              (rsp_error),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_samples_per_packet (csr_samples_per_packet)
   );

   // Offers one byte and returns at the edge where the transaction is accepted. Valid is only
   // lowered by a gap at the start of the next call or by drain, so back-to-back bytes keep it high.
   task automatic push_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_input(b);
      items_sent++;
   endtask

   // One complete frame: magic, channel, big-endian length, then the payload.
   task automatic send_frame(input logic [15:0] len, input hdr_mode_type mode);
      logic [7:0] b;
      int         i;
      push_byte(MAGIC_BYTE);
      push_byte(8'($urandom));
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      for (i = 0; i < int'(len); i++) begin
         b = 8'($urandom);
         if (i == 0) begin
            case (mode)
               HDR_KEEP:    b = RTP_V2;
               HDR_REWRITE: if (b == RTP_V2) b = b ^ 8'h01;
               default: ;
            endcase
         end
         push_byte(b);
      end
   endtask

   // Stops offering and waits until every predicted result has come back, plus a margin.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The sample increment is only changed with the block idle.
   task automatic write_samples(input logic [TS_W-1:0] value);
      drain();
      csr_valid              <= 1'b1;
      csr_samples_per_packet <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.set_samples(value);
      csr_valid <= 1'b0;
   endtask

   // Mostly short frames, a fair number of full headers, a few long payloads and some
   // zero-length frames. Idling is switched off for random stretches of frames.
   task automatic run_random(input int target);
      int        start;
      int        r;
      logic [15:0] len;
      hdr_mode_type mode;
      start = items_sent;
      while (items_sent - start < target) begin
         idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 5)
            len = 16'd0;
         else if (r < 40)
            len = 16'($urandom_range(1, 11));
         else if (r < 92)
            len = 16'($urandom_range(12, 40));
         else
            len = 16'($urandom_range(41, 300));
         r = $urandom_range(0, 99);
         mode = (r < 70) ? HDR_REWRITE : (r < 90) ? HDR_KEEP : HDR_ANY;
         send_frame(len, mode);
      end
   endtask

   // Result sink. It samples the handshake at each rising edge, then decides the next
   // value of rsp_ready: a long hold-off when one is requested, otherwise short random
   // stalls while idling is allowed.
   initial begin : result_sink
      int stall_left;
      int hold_left;
      bit ready_next;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready)
            sb.check_result(rsp_out_byte, rsp_last, rsp_error);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < STALL_PERCENT) begin
            stall_left = $urandom_range(1, 8) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin : stimulus
      logic [7:0] bad_magic;
      int         i;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, still at the reset increment. A zero-length frame produces
      // nothing and leaves the counters alone.
      push_byte(MAGIC_BYTE);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h00);
      // The first rewritten packet is either a single byte, which uses up the marker
      // without showing it, or a short packet that shows the marker on its second byte.
      // The seed decides which one this run sees.
      if ($urandom_range(0, 1) == 0) begin
         push_byte(MAGIC_BYTE);
         push_byte(8'h00);
         push_byte(8'h00);
         push_byte(8'h01);
         push_byte(8'hFF);
      end
      // A short packet: only the header bytes that are present get rewritten.
      push_byte(MAGIC_BYTE);
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte(8'h03);
      push_byte(8'h00);
      push_byte(8'h12);
      push_byte(8'h34);
      // A packet that already starts as RTP v2 passes through untouched.
      push_byte(MAGIC_BYTE);
      push_byte(8'h02);
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(RTP_V2);

      // Random phases, each at its own sample increment.
      write_samples('0);
      run_random(500);

      // Hold the receiver off for a long stretch while frames keep coming, so the block
      // backs up and throttles its input.
      write_samples('1);
      hold_request = HOLD_CYCLES;
      run_random(500);

      // Mid-phase the sender pauses until all results are back.
      write_samples(TS_W'($urandom));
      run_random(250);
      drain();
      run_random(250);

      write_samples(TS_W'(1));
      run_random(500);

      // Final part, no idling on either side.
      idle_on = 1'b0;
      write_samples(32'h8000_0000);
      // A few single-byte rewritten frames, then full headers back to back.
      repeat (4) send_frame(16'd1, HDR_REWRITE);
      repeat (3) send_frame(16'd12, HDR_REWRITE);

      // A broken frame start: one error result, then everything is swallowed, a correct
      // magic byte included.
      bad_magic = 8'($urandom);
      if (bad_magic == MAGIC_BYTE)
         bad_magic = bad_magic ^ 8'h80;
      push_byte(bad_magic);
      push_byte(MAGIC_BYTE);
      for (i = 0; i < 8; i++)
         push_byte(8'($urandom));

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule
